// ===== rtl/assert_macros.svh =====
// Assertion macros used by lsu_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lsu_pkg.sv =====
`default_nettype none

package lsu_pkg;

    // Data memory geometry. MEM_BYTES is a power of two, so a byte address is
    // the low MEM_AW bits of the 32-bit effective address.
    localparam int MEM_BYTES = 4096;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    // Register file geometry.
    localparam int REG_COUNT = 16;
    localparam int REG_AW    = 4;

    // Operation codes.
    localparam logic [3:0] OP_LDR   = 4'd0;
    localparam logic [3:0] OP_LDRH  = 4'd1;
    localparam logic [3:0] OP_LDRSH = 4'd2;
    localparam logic [3:0] OP_LDRB  = 4'd3;
    localparam logic [3:0] OP_LDRSB = 4'd4;
    localparam logic [3:0] OP_STR   = 4'd5;
    localparam logic [3:0] OP_STRH  = 4'd6;
    localparam logic [3:0] OP_STRB  = 4'd7;
    localparam logic [3:0] OP_SETR  = 4'd8;

    // Command beat.
    typedef struct packed {
        logic [3:0]  operation;
        logic [31:0] instruction;
        logic [31:0] preload_value;
    } lsu_cmd_t;

    // Result beat.
    typedef struct packed {
        logic [11:0] byte_address;
        logic [3:0]  reg_index;
        logic [31:0] reg_value;
        logic        wrote_register;
    } lsu_res_t;

    // Request to the shared adder/subtractor.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        sub;
    } alu_req_t;

endpackage

`default_nettype wire

// ===== rtl/lsu_alu.sv =====
`default_nettype none

module lsu_alu
    import lsu_pkg::*;
(
    input  alu_req_t    req,
    output logic [32:0] sum
);

    logic [31:0] b_eff;

    // Two's complement subtract folds into the add through the carry in.
    assign b_eff = req.sub ? ~req.b : req.b;
    assign sum   = {1'b0, req.a} + {1'b0, b_eff} + {32'd0, req.sub};

endmodule

`default_nettype wire

// ===== rtl/load_store_unit_core.sv =====
`default_nettype none

// Channel | Direction | Handshake            | Payload
// cmd     | in        | cmd_valid, cmd_ready | cmd (lsu_cmd_t)
// res     | out       | res_valid, res_ready | res (lsu_res_t)
//
// Set register and unused codes go from accept straight to S_FIN to register the result.
// Loads and stores pass S_BASE, S_DATA, S_BYTE per byte (one port access), S_WAIT, S_FIN.
// After reset a clearing pass over every address zeroes the memory and register file;
// cmd_ready stays low during it.
// A stalled result waits in the output register while a new command is taken;
// the sequencer holds in its last state only if a second result is ready.

module load_store_unit_core
    import lsu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_ready,
    input  wire lsu_cmd_t cmd,
    output logic          res_valid,
    input  wire logic     res_ready,
    output lsu_res_t      res
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b000_0001,
        S_IDLE  = 7'b000_0010,
        S_BASE  = 7'b000_0100,
        S_DATA  = 7'b000_1000,
        S_BYTE  = 7'b001_0000,
        S_WAIT  = 7'b010_0000,
        S_FIN   = 7'b100_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [MEM_AW-1:0]   clr_reg, clr_next;
    lsu_cmd_t            cmd_reg, cmd_next;
    logic [31:0]         ea_reg, ea_next;
    logic [31:0]         data_reg, data_next;
    logic [MEM_AW-1:0]   addr_reg, addr_next;
    logic [MEM_AW-1:0]   first_reg, first_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [1:0]          last_reg, last_next;
    logic                pend_reg, pend_next;
    logic [1:0]          lane_reg, lane_next;
    logic [31:0]         load_word_reg, load_word_next;
    logic                res_valid_reg, res_valid_next;
    lsu_res_t            res_reg, res_next;

    // Memories and their ports.
    logic [7:0]          mem [MEM_BYTES];
    logic [7:0]          mem_rdata_reg;
    logic                mem_we;
    logic [MEM_AW-1:0]   mem_addr;
    logic [7:0]          mem_wdata;

    logic [31:0]         rf_mem [REG_COUNT];
    logic [31:0]         rf_rdata_reg;
    logic                rf_we;
    logic [REG_AW-1:0]   rf_waddr;
    logic [REG_AW-1:0]   rf_raddr;
    logic [31:0]         rf_wdata;

    // Shared adder.
    alu_req_t            alu_req;
    logic [32:0]         alu_sum;

    // Decoded fields of the held command.
    logic [3:0]          op;
    logic                up;
    logic [REG_AW-1:0]   rd;
    logic                split;
    logic [31:0]         offset;
    logic                is_store;
    logic                is_mem;
    logic                wr_reg;
    logic [31:0]         value;
    logic [31:0]         first_wide;

    lsu_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    // Decode of the held command.
    always_comb
    begin
        op       = cmd_reg.operation;
        up       = cmd_reg.instruction[23];
        rd       = cmd_reg.instruction[15:12];
        split    = (op == OP_LDRH) || (op == OP_LDRSH) || (op == OP_LDRSB) || (op == OP_STRH);
        offset   = split ? {24'd0, cmd_reg.instruction[11:8], cmd_reg.instruction[3:0]}
                         : {20'd0, cmd_reg.instruction[11:0]};
        is_store = (op == OP_STR) || (op == OP_STRH) || (op == OP_STRB);
        is_mem   = (op <= OP_STRB);
        wr_reg   = (op <= OP_LDRSB) || (op == OP_SETR);
        first_wide = 32'(first_reg);
    end

    // Result value by operation.
    always_comb
    begin
        unique case (op)
            OP_LDR:   value = load_word_reg;
            OP_LDRH:  value = {16'd0, load_word_reg[15:0]};
            OP_LDRSH: value = {{16{load_word_reg[15]}}, load_word_reg[15:0]};
            OP_LDRB:  value = {24'd0, load_word_reg[7:0]};
            OP_LDRSB: value = {{24{load_word_reg[7]}}, load_word_reg[7:0]};
            OP_STR:   value = data_reg;
            OP_STRH:  value = {16'd0, data_reg[15:0]};
            OP_STRB:  value = {24'd0, data_reg[7:0]};
            OP_SETR:  value = cmd_reg.preload_value;
            default:  value = 32'd0;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        ea_next        = ea_reg;
        data_next      = data_reg;
        addr_next      = addr_reg;
        first_next     = first_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        pend_next      = 1'b0;
        lane_next      = lane_reg;
        load_word_next = load_word_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_addr       = addr_reg;
        mem_wdata      = data_reg[{cnt_reg, 3'b000} +: 8];
        rf_we          = 1'b0;
        rf_waddr       = rd;
        rf_raddr       = rd;
        rf_wdata       = value;
        alu_req        = '0;

        // A byte read issued last cycle lands in its lane now.
        if (pend_reg)
        begin
            load_word_next[{lane_reg, 3'b000} +: 8] = mem_rdata_reg;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = 8'd0;
                rf_we     = (32'(clr_reg) < 32'(REG_COUNT));
                rf_waddr  = clr_reg[REG_AW-1:0];
                rf_wdata  = 32'd0;
                if (clr_reg == MEM_AW'(MEM_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                // The base register is read every cycle so it is ready after accept.
                rf_raddr = cmd.instruction[19:16];
                if (cmd_valid)
                begin
                    cmd_next       = cmd;
                    load_word_next = 32'd0;
                    if ((cmd.operation == OP_LDR) || (cmd.operation == OP_STR))
                    begin
                        last_next = 2'd3;
                    end
                    else if ((cmd.operation == OP_LDRH) || (cmd.operation == OP_LDRSH)
                             || (cmd.operation == OP_STRH))
                    begin
                        last_next = 2'd1;
                    end
                    else
                    begin
                        last_next = 2'd0;
                    end
                    state_next = (cmd.operation <= OP_STRB) ? S_BASE : S_FIN;
                end
            end
            S_BASE:
            begin
                alu_req.a   = rf_rdata_reg;
                alu_req.b   = offset;
                alu_req.sub = !up;
                ea_next     = alu_sum[31:0];
                state_next  = S_DATA;
            end
            S_DATA:
            begin
                // The memory address is the low bits of the effective address.
                data_next  = rf_rdata_reg;
                addr_next  = ea_reg[MEM_AW-1:0];
                first_next = ea_reg[MEM_AW-1:0];
                cnt_next   = 2'd0;
                state_next = S_BYTE;
            end
            S_BYTE:
            begin
                // One byte per cycle; a carry out of the 32-bit address restarts at zero.
                mem_addr  = addr_reg;
                alu_req.a = ea_reg;
                alu_req.b = 32'd1;
                ea_next   = alu_sum[31:0];
                if (alu_sum[32] || (addr_reg == MEM_AW'(MEM_BYTES - 1)))
                begin
                    addr_next = '0;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
                if (is_store)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    pend_next = 1'b1;
                    lane_next = cnt_reg;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == last_reg)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.byte_address   = is_mem ? first_wide[11:0] : 12'd0;
                    res_next.reg_index      = rd;
                    res_next.reg_value      = value;
                    res_next.wrote_register = wr_reg;
                    res_valid_next          = 1'b1;
                    rf_we                   = wr_reg;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= 2'd0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        ea_reg        <= ea_next;
        data_reg      <= data_next;
        addr_reg      <= addr_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        lane_reg      <= lane_next;
        load_word_reg <= load_word_next;
        res_reg       <= res_next;
    end

    // Byte-wide data memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr];
    end

    // Register file with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        rf_rdata_reg <= rf_mem[rf_raddr];
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== rtl/lsu_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module lsu_checker
    import lsu_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     cmd_valid,
    input wire logic     cmd_ready,
    input wire lsu_cmd_t cmd,
    input wire logic     res_valid,
    input wire logic     res_ready,
    input wire lsu_res_t res
);

    // A stalled result beat stays up and unchanged.
    `LSU_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(res), "result beat changed under stall")

    // The unit takes one command at a time.
    `LSU_ASSERT_NXT(a_one_cmd, clk, rst_n, cmd_valid && cmd_ready,
        !cmd_ready, "command taken while busy")

    // A reported address always lies inside the data memory.
    `LSU_ASSERT_IMP(a_addr_range, clk, rst_n, res_valid,
        32'(res.byte_address) < 32'(MEM_BYTES), "address outside memory")

endmodule

bind load_store_unit_core lsu_checker u_lsu_checker (.*);

`default_nettype wire
